### rtl/mtsq_pkg.sv
// Package for the matrix to scale and quaternion block.
// Holds field widths, pipeline depths, the branch code type and the
// single-step square root and division helpers. No dependencies.
package mtsq_pkg;

  localparam int ElemW       = 24;   // Q8.16 matrix entry
  localparam int QuatW       = 18;   // Q1.16 quaternion component
  localparam int RadW        = 48;   // square root radicand
  localparam int RemW        = 43;   // divider remainder
  localparam int QBits       = 17;   // divider quotient bits
  localparam int FracW       = 16;
  localparam int Sqrt1Steps  = 24;   // root bits of a column length
  localparam int Sqrt2Steps  = 18;   // root bits of the trace divisor
  localparam logic [QBits-1:0] OneQ16 = QBits'(65536);

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [QuatW-1:0] quat_t;

  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } br_t;

  typedef struct packed {
    logic [RadW-1:0] x;
    logic [RadW-1:0] res;
  } sqrt_st_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QBits-1:0] q;
  } div_st_t;

  // One restoring step of the integer square root, for root bit k
  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, int k);
    logic [RadW-1:0] bitv;
    logic [RadW-1:0] trial;
    sqrt_st_t        o;
    bitv  = RadW'(1) << (2 * k);
    trial = st.res + bitv;
    if (st.x >= trial) begin
      o.x   = st.x - trial;
      o.res = (st.res >> 1) + bitv;
    end else begin
      o.x   = st.x;
      o.res = st.res >> 1;
    end
    return o;
  endfunction

  // One restoring step of the divider, producing quotient bit i
  function automatic div_st_t div_step(div_st_t st, logic [RemW-1:0] d, int i);
    logic [RemW-1:0] dsh;
    div_st_t         o;
    dsh = d << i;
    o   = st;
    if (st.rem >= dsh) begin
      o.rem = st.rem - dsh;
      o.q   = st.q | (QBits'(1) << i);
    end
    return o;
  endfunction

endpackage

### rtl/matrix_to_scale_and_quaternion.sv
// Top level: column lengths and trace-method quaternion of a 3x3 matrix.
// Depends on mtsq_pkg (widths, branch codes, square root and divide steps).
//
// Takes one Q8.16 matrix per cycle while no result waits untaken at the
// output, and returns its three column lengths and the Q1.16 quaternion of
// the normalised matrix. The pipeline is a chain of bit-per-stage units:
// a 24-stage square root for the lengths, a 17-step divider for normalising,
// an 18-stage square root for the trace divisor and a 17-step divider for
// the off-diagonal terms. The whole pipeline holds while a result waits at
// the output and moves when it is taken; a zero column or zero divisor
// raises degenerate with a zero quaternion.
module matrix_to_scale_and_quaternion (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [23:0]          in_col0_row0,
  input  logic signed [23:0]          in_col0_row1,
  input  logic signed [23:0]          in_col0_row2,
  input  logic signed [23:0]          in_col1_row0,
  input  logic signed [23:0]          in_col1_row1,
  input  logic signed [23:0]          in_col1_row2,
  input  logic signed [23:0]          in_col2_row0,
  input  logic signed [23:0]          in_col2_row1,
  input  logic signed [23:0]          in_col2_row2,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [23:0]                 out_scale_x,
  output logic [23:0]                 out_scale_y,
  output logic [23:0]                 out_scale_z,
  output logic signed [17:0]          out_quat_w,
  output logic signed [17:0]          out_quat_x,
  output logic signed [17:0]          out_quat_y,
  output logic signed [17:0]          out_quat_z,
  output logic                        out_degenerate
);

  localparam int S1N = mtsq_pkg::Sqrt1Steps;
  localparam int S2N = mtsq_pkg::Sqrt2Steps;
  localparam int QB  = mtsq_pkg::QBits;
  localparam int DN  = QB + 1;
  localparam int Lat = 2 + S1N + DN + 1 + S2N + DN + 1;
  localparam int RW  = mtsq_pkg::RemW;

  logic           adv;
  logic [Lat-1:0] v_r;

  mtsq_pkg::elem_t e_in [9];

  // stage A/B: squares and their sums
  mtsq_pkg::elem_t a_e_r  [9];
  logic [46:0]     a_sq_r [9];
  mtsq_pkg::elem_t b_e_r  [9];
  logic [47:0]     b_rad_r [3];

  // column length square roots
  mtsq_pkg::sqrt_st_t s1_st_r [S1N][3];
  mtsq_pkg::elem_t    s1_e_r  [S1N][9];

  // normalising dividers
  mtsq_pkg::div_st_t d1_st_r  [DN][9];
  logic [23:0]       d1_sc_r  [DN][3];
  logic [8:0]        d1_neg_r [DN];
  logic              d1_dg_r  [DN];

  // trace and branch
  logic signed [17:0] m_w [9];
  logic signed [19:0] tr_w;
  logic signed [19:0] arg_w;
  logic signed [18:0] d21_w, d02_w, d10_w, a01_w, a02_w, a12_w;
  mtsq_pkg::br_t      br_nxt;
  logic signed [18:0] num_nxt [3];
  logic [47:0]        t_rad_r;
  logic signed [18:0] t_num_r [3];
  mtsq_pkg::br_t      t_br_r;
  logic               t_dg_r;
  logic [23:0]        t_sc_r [3];

  // divisor square root
  mtsq_pkg::sqrt_st_t s2_st_r  [S2N];
  logic signed [18:0] s2_num_r [S2N][3];
  mtsq_pkg::br_t      s2_br_r  [S2N];
  logic               s2_dg_r  [S2N];
  logic [23:0]        s2_sc_r  [S2N][3];

  // off-diagonal dividers
  logic [17:0]        rt_w;
  logic [18:0]        sdiv_w;
  mtsq_pkg::div_st_t  d2_st_r  [DN][3];
  logic [17:0]        d2_rt_r  [DN];
  logic [2:0]         d2_neg_r [DN];
  logic [2:0]         d2_ov_r  [DN];
  mtsq_pkg::br_t      d2_br_r  [DN];
  logic               d2_dg_r  [DN];
  logic [23:0]        d2_sc_r  [DN][3];

  // output stage
  logic [18:0]        half_w;
  logic signed [17:0] off_w [3];
  logic signed [17:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic [23:0]        sc_x_r, sc_y_r, sc_z_r;
  logic signed [17:0] qw_r, qx_r, qy_r, qz_r;
  logic               dg_r;

  // move the whole pipeline unless the output holds an untaken result
  assign adv      = out_ready || !v_r[Lat-1];
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Lat-2:0], in_valid};
    end
  end

  assign e_in[0] = in_col0_row0;
  assign e_in[1] = in_col0_row1;
  assign e_in[2] = in_col0_row2;
  assign e_in[3] = in_col1_row0;
  assign e_in[4] = in_col1_row1;
  assign e_in[5] = in_col1_row2;
  assign e_in[6] = in_col2_row0;
  assign e_in[7] = in_col2_row1;
  assign e_in[8] = in_col2_row2;

  // square each entry, then sum per column
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        a_e_r[i]  <= e_in[i];
        a_sq_r[i] <= 47'(e_in[i] * e_in[i]);
        b_e_r[i]  <= a_e_r[i];
      end
      for (int c = 0; c < 3; c++) begin
        b_rad_r[c] <= 48'(a_sq_r[3*c]) + 48'(a_sq_r[3*c+1]) + 48'(a_sq_r[3*c+2]);
      end
    end
  end

  // column lengths, one root bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s1_st_r[0][c] <= mtsq_pkg::sqrt_step('{x: b_rad_r[c], res: '0}, S1N - 1);
        for (int j = 1; j < S1N; j++) begin
          s1_st_r[j][c] <= mtsq_pkg::sqrt_step(s1_st_r[j-1][c], S1N - 1 - j);
        end
      end
      for (int i = 0; i < 9; i++) begin
        s1_e_r[0][i] <= b_e_r[i];
        for (int j = 1; j < S1N; j++) begin
          s1_e_r[j][i] <= s1_e_r[j-1][i];
        end
      end
    end
  end

  // divide each entry by its column length, rounded half away from zero
  always_ff @(posedge clk) begin
    logic [23:0] sc;
    logic [23:0] mag;
    logic        dg;
    if (adv) begin
      dg = 1'b0;
      for (int c = 0; c < 3; c++) begin
        sc = s1_st_r[S1N-1][c].res[23:0];
        d1_sc_r[0][c] <= sc;
        if (sc == '0) begin
          dg = 1'b1;
        end
        for (int r = 0; r < 3; r++) begin
          mag = s1_e_r[S1N-1][3*c+r][23] ? 24'(-s1_e_r[S1N-1][3*c+r])
                                         : 24'(s1_e_r[S1N-1][3*c+r]);
          d1_neg_r[0][3*c+r] <= s1_e_r[S1N-1][3*c+r][23];
          d1_st_r[0][3*c+r]  <= '{rem: (RW'(mag) << QB) + RW'(sc), q: '0};
        end
      end
      d1_dg_r[0] <= dg;
      for (int j = 1; j < DN; j++) begin
        d1_neg_r[j] <= d1_neg_r[j-1];
        d1_dg_r[j]  <= d1_dg_r[j-1];
        for (int c = 0; c < 3; c++) begin
          d1_sc_r[j][c] <= d1_sc_r[j-1][c];
          for (int r = 0; r < 3; r++) begin
            d1_st_r[j][3*c+r] <= mtsq_pkg::div_step(d1_st_r[j-1][3*c+r],
                                   RW'(d1_sc_r[j-1][c]) << 1, QB - j);
          end
        end
      end
    end
  end

  // trace, branch choice and the branch's numerators
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m_w[i] = d1_neg_r[DN-1][i] ? -$signed({1'b0, d1_st_r[DN-1][i].q})
                                 :  $signed({1'b0, d1_st_r[DN-1][i].q});
    end
    // m_rc sits at index 3*c + r
    tr_w  = 20'(m_w[0]) + 20'(m_w[4]) + 20'(m_w[8]);
    d21_w = 19'(m_w[5]) - 19'(m_w[7]);
    d02_w = 19'(m_w[6]) - 19'(m_w[2]);
    d10_w = 19'(m_w[1]) - 19'(m_w[3]);
    a01_w = 19'(m_w[3]) + 19'(m_w[1]);
    a02_w = 19'(m_w[6]) + 19'(m_w[2]);
    a12_w = 19'(m_w[7]) + 19'(m_w[5]);
    if (tr_w > 0) begin
      br_nxt = mtsq_pkg::BR_TRACE;
      arg_w  = 20'sd65536 + tr_w;
      num_nxt[0] = d21_w; num_nxt[1] = d02_w; num_nxt[2] = d10_w;
    end else if (m_w[0] > m_w[4] && m_w[0] > m_w[8]) begin
      br_nxt = mtsq_pkg::BR_X;
      arg_w  = 20'sd65536 + 20'(m_w[0]) - 20'(m_w[4]) - 20'(m_w[8]);
      num_nxt[0] = d21_w; num_nxt[1] = a01_w; num_nxt[2] = a02_w;
    end else if (m_w[4] > m_w[8]) begin
      br_nxt = mtsq_pkg::BR_Y;
      arg_w  = 20'sd65536 + 20'(m_w[4]) - 20'(m_w[0]) - 20'(m_w[8]);
      num_nxt[0] = d02_w; num_nxt[1] = a01_w; num_nxt[2] = a12_w;
    end else begin
      br_nxt = mtsq_pkg::BR_Z;
      arg_w  = 20'sd65536 + 20'(m_w[8]) - 20'(m_w[0]) - 20'(m_w[4]);
      num_nxt[0] = d10_w; num_nxt[1] = a02_w; num_nxt[2] = a12_w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_rad_r <= (arg_w > 0) ? (48'(arg_w) << mtsq_pkg::FracW) : '0;
      t_br_r  <= br_nxt;
      t_dg_r  <= d1_dg_r[DN-1];
      for (int k = 0; k < 3; k++) begin
        t_num_r[k] <= num_nxt[k];
        t_sc_r[k]  <= d1_sc_r[DN-1][k];
      end
    end
  end

  // root of the branch argument, one bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_st_r[0] <= mtsq_pkg::sqrt_step('{x: t_rad_r, res: '0}, S2N - 1);
      s2_br_r[0] <= t_br_r;
      s2_dg_r[0] <= t_dg_r;
      for (int k = 0; k < 3; k++) begin
        s2_num_r[0][k] <= t_num_r[k];
        s2_sc_r[0][k]  <= t_sc_r[k];
      end
      for (int j = 1; j < S2N; j++) begin
        s2_st_r[j] <= mtsq_pkg::sqrt_step(s2_st_r[j-1], S2N - 1 - j);
        s2_br_r[j] <= s2_br_r[j-1];
        s2_dg_r[j] <= s2_dg_r[j-1];
        for (int k = 0; k < 3; k++) begin
          s2_num_r[j][k] <= s2_num_r[j-1][k];
          s2_sc_r[j][k]  <= s2_sc_r[j-1][k];
        end
      end
    end
  end

  assign rt_w   = s2_st_r[S2N-1].res[17:0];
  assign sdiv_w = {rt_w, 1'b0};

  // divide the off-diagonal terms by s; flag quotients past 17 bits
  always_ff @(posedge clk) begin
    logic [17:0]   mag;
    logic [RW-1:0] nn;
    if (adv) begin
      d2_rt_r[0] <= rt_w;
      d2_br_r[0] <= s2_br_r[S2N-1];
      d2_dg_r[0] <= s2_dg_r[S2N-1] || (rt_w == '0);
      for (int k = 0; k < 3; k++) begin
        mag = s2_num_r[S2N-1][k][18] ? 18'(-s2_num_r[S2N-1][k])
                                     : 18'(s2_num_r[S2N-1][k]);
        nn  = (RW'(mag) << QB) + RW'(sdiv_w);
        d2_st_r[0][k]  <= '{rem: nn, q: '0};
        d2_neg_r[0][k] <= s2_num_r[S2N-1][k][18];
        d2_ov_r[0][k]  <= nn >= ((RW'(sdiv_w) << 1) << QB);
        d2_sc_r[0][k]  <= s2_sc_r[S2N-1][k];
      end
      for (int j = 1; j < DN; j++) begin
        d2_rt_r[j]  <= d2_rt_r[j-1];
        d2_br_r[j]  <= d2_br_r[j-1];
        d2_dg_r[j]  <= d2_dg_r[j-1];
        d2_neg_r[j] <= d2_neg_r[j-1];
        d2_ov_r[j]  <= d2_ov_r[j-1];
        for (int k = 0; k < 3; k++) begin
          d2_st_r[j][k] <= mtsq_pkg::div_step(d2_st_r[j-1][k],
                             RW'({d2_rt_r[j-1], 1'b0}) << 1, QB - j);
          d2_sc_r[j][k] <= d2_sc_r[j-1][k];
        end
      end
    end
  end

  // saturate, sign and place the components by branch
  always_comb begin
    logic [QB-1:0] qm;
    half_w = (19'(d2_rt_r[DN-1]) + 19'd1) >> 1;
    for (int k = 0; k < 3; k++) begin
      qm = (d2_ov_r[DN-1][k] || d2_st_r[DN-1][k].q > mtsq_pkg::OneQ16)
           ? mtsq_pkg::OneQ16 : d2_st_r[DN-1][k].q;
      off_w[k] = d2_neg_r[DN-1][k] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end
    case (d2_br_r[DN-1])
      mtsq_pkg::BR_TRACE: begin
        qw_nxt = $signed(half_w[17:0]);
        qx_nxt = off_w[0]; qy_nxt = off_w[1]; qz_nxt = off_w[2];
      end
      mtsq_pkg::BR_X: begin
        qw_nxt = off_w[0]; qx_nxt = $signed(half_w[17:0]);
        qy_nxt = off_w[1]; qz_nxt = off_w[2];
      end
      mtsq_pkg::BR_Y: begin
        qw_nxt = off_w[0]; qx_nxt = off_w[1];
        qy_nxt = $signed(half_w[17:0]); qz_nxt = off_w[2];
      end
      default: begin
        qw_nxt = off_w[0]; qx_nxt = off_w[1]; qy_nxt = off_w[2];
        qz_nxt = $signed(half_w[17:0]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_x_r <= d2_sc_r[DN-1][0];
      sc_y_r <= d2_sc_r[DN-1][1];
      sc_z_r <= d2_sc_r[DN-1][2];
      dg_r   <= d2_dg_r[DN-1];
      qw_r   <= d2_dg_r[DN-1] ? '0 : qw_nxt;
      qx_r   <= d2_dg_r[DN-1] ? '0 : qx_nxt;
      qy_r   <= d2_dg_r[DN-1] ? '0 : qy_nxt;
      qz_r   <= d2_dg_r[DN-1] ? '0 : qz_nxt;
    end
  end

  assign out_valid      = v_r[Lat-1];
  assign out_scale_x    = sc_x_r;
  assign out_scale_y    = sc_y_r;
  assign out_scale_z    = sc_z_r;
  assign out_quat_w     = qw_r;
  assign out_quat_x     = qx_r;
  assign out_quat_y     = qy_r;
  assign out_quat_z     = qz_r;
  assign out_degenerate = dg_r;

endmodule
